// ----- sv/ttd_pkg.sv -----
// Package for the timed task dispatcher: sizes, op codes, shared types.
// No dependencies.
package ttd_pkg;
	localparam int TASKS     = 8;
	localparam int TIME_BITS = 32;
	localparam int SW        = $clog2(TASKS);
	localparam int LW        = $clog2(TASKS + 1);

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_STOP   = 3'd1,
		OP_REARM  = 3'd2,
		OP_WAKE   = 3'd3,
		OP_POLL   = 3'd4,
		OP_DONE   = 3'd5,
		OP_READ   = 3'd6,
		OP_NOP    = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_OUT
	} state_t;

	// command broadcast to every cell of a chain
	typedef struct packed {
		logic                 remove;
		logic                 insert;
		logic                 append;
		logic [SW-1:0]        slot;
		logic [TIME_BITS-1:0] key;
	} chain_cmd_t;

	// wrap-safe: a is at or after b
	function automatic logic time_ge(input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS-1:0] d;
		d = a - b;
		return ~d[TIME_BITS-1];
	endfunction
endpackage

// ----- sv/ttd_if.sv -----
// Valid/ready stream interfaces for the dispatcher's request and result.
// Depends on ttd_pkg.
interface ttd_req_if import ttd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           op;
	logic [2:0]           task_req;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] when;
	logic [TIME_BITS-1:0] interval;
	logic                 async_rearm;
	logic                 keep_interval;
	modport source (output valid, op, task_req, now, when, interval, async_rearm,
		keep_interval, input ready);
	modport sink (input valid, op, task_req, now, when, interval, async_rearm,
		keep_interval, output ready);
endinterface

interface ttd_rsp_if ();
	logic        valid;
	logic        ready;
	logic        dispatch_valid;
	logic [2:0]  dispatched_task;
	logic [15:0] wakeup_total;
	logic        task_active;
	modport source (output valid, dispatch_valid, dispatched_task, wakeup_total,
		task_active, input ready);
	modport sink (input valid, dispatch_valid, dispatched_task, wakeup_total,
		task_active, output ready);
endinterface

// ----- sv/ttd_cell.sv -----
// One cell of an ordered slot chain: holds one slot id and its key.
// Depends on ttd_pkg. Shifts toward the head on remove, toward the tail on insert.
module ttd_cell import ttd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  chain_cmd_t           cmd,
	input  logic                 ordered,
	// neighbor toward the head
	input  logic                 prev_vld,
	input  logic [SW-1:0]        prev_slot,
	input  logic [TIME_BITS-1:0] prev_key,
	input  logic                 prev_keep,
	// neighbor toward the tail
	input  logic                 next_vld,
	input  logic [SW-1:0]        next_slot,
	input  logic [TIME_BITS-1:0] next_key,
	input  logic                 next_shift,
	output logic                 vld,
	output logic [SW-1:0]        slot,
	output logic [TIME_BITS-1:0] key,
	output logic                 keep,
	output logic                 shift
);
	logic vld_q;
	logic [SW-1:0] slot_q;
	logic [TIME_BITS-1:0] key_q;

	// keep: entry stays ahead of the new one (insert) / ahead of the hit (remove)
	always_comb begin
		if (cmd.remove)
			keep = prev_keep & ~(vld_q & slot_q == cmd.slot);
		else if (ordered)
			keep = prev_keep & vld_q & time_ge(cmd.key, key_q);
		else
			keep = prev_keep & vld_q;
		shift = ~keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.remove) begin
			if (!keep) begin
				vld_q <= next_vld;
				slot_q <= next_slot;
				key_q <= next_key;
			end
		end else if (cmd.insert | cmd.append) begin
			if (!keep) begin
				if (prev_keep) begin
					vld_q <= 1'b1;
					slot_q <= cmd.slot;
					key_q <= cmd.key;
				end else begin
					vld_q <= prev_vld;
					slot_q <= prev_slot;
					key_q <= prev_key;
				end
			end
		end
	end

	assign vld = vld_q;
	assign slot = slot_q;
	assign key = key_q;
	logic unused;
	assign unused = next_shift;
endmodule

// ----- sv/ttd_chain.sv -----
// Row of ttd_cell forming an ordered list (time order or FIFO order).
// Depends on ttd_pkg, ttd_cell.
module ttd_chain import ttd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  chain_cmd_t            cmd,
	input  logic                  ordered,
	output logic [TASKS-1:0]      vld,
	output logic [TASKS-1:0][SW-1:0] slots,
	output logic [TIME_BITS-1:0]  head_key
);
	logic [TASKS:0] keep_c;
	logic [TASKS:0] shift_c;
	logic [TASKS-1:0][TIME_BITS-1:0] keys;
	assign keep_c[0] = 1'b1;
	assign shift_c[TASKS] = 1'b0;

	for (genvar i = 0; i < TASKS; i++) begin : g_cell
		logic pv, nv;
		logic [SW-1:0] ps, ns;
		logic [TIME_BITS-1:0] pk, nk;
		if (i == 0) begin : g_h
			assign pv = 1'b0; assign ps = '0; assign pk = '0;
		end else begin : g_m
			assign pv = vld[i-1]; assign ps = slots[i-1]; assign pk = keys[i-1];
		end
		if (i == TASKS - 1) begin : g_t
			assign nv = 1'b0; assign ns = '0; assign nk = '0;
		end else begin : g_n
			assign nv = vld[i+1]; assign ns = slots[i+1]; assign nk = keys[i+1];
		end
		ttd_cell u_cell (
			.clk, .arst_n, .cmd, .ordered,
			.prev_vld(pv), .prev_slot(ps), .prev_key(pk), .prev_keep(keep_c[i]),
			.next_vld(nv), .next_slot(ns), .next_key(nk), .next_shift(shift_c[i+1]),
			.vld(vld[i]), .slot(slots[i]), .key(keys[i]),
			.keep(keep_c[i+1]), .shift(shift_c[i])
		);
	end
	assign head_key = keys[0];
endmodule

// ----- sv/timed_task_dispatcher.sv -----
// Top level of the timed task dispatcher: slot registers, two cell chains, sequencer.
// Depends on ttd_pkg, ttd_if, ttd_chain.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | op, task_req, now, when, interval, async_rearm, keep_interval
//  rsp     | out | valid/ready | dispatch_valid, dispatched_task, wakeup_total, task_active
//
// Every request passes through the accepting cycle, remove, insert and the result cycle;
// the time chain's remove and its sorted insert each have a state of their own.
// The next request is taken once the result register is free.
// Reset clears all slots and empties both chains at once.
// A stalled result holds in its register; req.ready stays low meanwhile.
module timed_task_dispatcher import ttd_pkg::*; (
	input logic clk,
	input logic arst_n,
	ttd_req_if.sink   req,
	ttd_rsp_if.source rsp
);
	state_t state_q, state_d;
	logic [TIME_BITS-1:0] due_q [TASKS];
	logic [TIME_BITS-1:0] ival_q [TASKS];
	logic [TASKS-1:0] act_q, stp_q;
	logic [15:0] wcnt_q [TASKS];
	logic run_vld_q;
	logic [SW-1:0] run_q;

	// latched request
	op_t op_q;
	logic [SW-1:0] s_q;
	logic ok_q;
	logic [TIME_BITS-1:0] now_q, when_q, ival_in_q;
	logic async_q, keep_q;
	logic ins_q;
	logic [SW-1:0] ins_slot_q;
	logic dv_q; logic [SW-1:0] dt_q; logic [15:0] tot_q;

	chain_cmd_t tcmd, wcmd;
	logic [TASKS-1:0] tvld, wvld;
	logic [TASKS-1:0][SW-1:0] tsl, wsl;
	logic [TIME_BITS-1:0] thead_key, whead_key;

	ttd_chain u_tlist (.clk, .arst_n, .cmd(tcmd), .ordered(1'b1),
		.vld(tvld), .slots(tsl), .head_key(thead_key));
	ttd_chain u_wfifo (.clk, .arst_n, .cmd(wcmd), .ordered(1'b0),
		.vld(wvld), .slots(wsl), .head_key(whead_key));

	logic accept;
	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid & req.ready;

	// queued lookup
	logic in_tlist;
	always_comb begin
		in_tlist = 1'b0;
		for (int i = 0; i < TASKS; i++)
			if (tvld[i] && tsl[i] == s_q) in_tlist = 1'b1;
	end

	logic poll_go, poll_fifo;
	logic [SW-1:0] poll_slot;
	always_comb begin
		poll_go = 1'b0; poll_fifo = 1'b0; poll_slot = '0;
		if (!run_vld_q) begin
			if (wvld[0]) begin
				poll_go = 1'b1; poll_fifo = 1'b1; poll_slot = wsl[0];
			end else if (tvld[0] && time_ge(now_q, thead_key)) begin
				poll_go = 1'b1; poll_slot = tsl[0];
			end
		end
	end

	// next state
	always_comb begin
		unique case (state_q)
			ST_IDLE:   state_d = accept ? ST_REMOVE : ST_IDLE;
			ST_REMOVE: state_d = ST_INSERT;
			ST_INSERT: state_d = ST_OUT;
			ST_OUT:    state_d = rsp.ready ? ST_IDLE : ST_OUT;
			default:   state_d = ST_IDLE;
		endcase
	end

	// chain commands
	always_comb begin
		tcmd = '0; wcmd = '0;
		tcmd.key = due_q[ins_slot_q];
		unique case (state_q)
			ST_REMOVE: begin
				if (ok_q) begin
					unique case (op_q)
						OP_START: begin
							tcmd.remove = 1'b1; tcmd.slot = s_q;
							wcmd.remove = 1'b1; wcmd.slot = s_q;
						end
						OP_STOP: if (act_q[s_q] && !stp_q[s_q] &&
							!(run_vld_q && run_q == s_q)) begin
							tcmd.remove = 1'b1; tcmd.slot = s_q;
							wcmd.remove = 1'b1; wcmd.slot = s_q;
						end
						OP_REARM: if (in_tlist) begin
							tcmd.remove = 1'b1; tcmd.slot = s_q;
						end
						OP_WAKE: if (act_q[s_q] && wcnt_q[s_q] == 16'd0) begin
							wcmd.append = 1'b1; wcmd.slot = s_q;
						end
						OP_READ: if (wcnt_q[s_q] != 16'd0) begin
							wcmd.remove = 1'b1; wcmd.slot = s_q;
						end
						default: ;
					endcase
				end
				if (op_q == OP_POLL && poll_go) begin
					tcmd.remove = 1'b1; tcmd.slot = poll_slot;
					wcmd.remove = poll_fifo; wcmd.slot = poll_slot;
				end
				if (op_q == OP_DONE && run_vld_q) begin
					tcmd.remove = 1'b1; tcmd.slot = run_q;
					if (stp_q[run_q] || ival_q[run_q] == '0) begin
						wcmd.remove = 1'b1; wcmd.slot = run_q;
					end
				end
			end
			ST_INSERT: begin
				tcmd.insert = ins_q; tcmd.slot = ins_slot_q;
			end
			default: ;
		endcase
	end

	// sequencer and slot registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_vld_q <= 1'b0;
			run_q <= '0;
			act_q <= '0;
			stp_q <= '0;
			ins_q <= 1'b0;
			for (int i = 0; i < TASKS; i++) begin
				due_q[i] <= '0; ival_q[i] <= '0; wcnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= op_t'(req.op);
				s_q <= req.task_req[SW-1:0];
				ok_q <= ({3'b0, req.task_req} < 6'(TASKS));
				now_q <= req.now; when_q <= req.when; ival_in_q <= req.interval;
				async_q <= req.async_rearm; keep_q <= req.keep_interval;
				dv_q <= 1'b0; dt_q <= '0; tot_q <= '0;
			end
			if (state_q == ST_REMOVE) begin
				ins_q <= 1'b0;
				ins_slot_q <= s_q;
				if (ok_q) begin
					unique case (op_q)
						OP_START: begin
							due_q[s_q] <= when_q; ival_q[s_q] <= ival_in_q;
							wcnt_q[s_q] <= '0; act_q[s_q] <= 1'b1; stp_q[s_q] <= 1'b0;
							ins_q <= 1'b1;
						end
						OP_STOP: if (act_q[s_q] && !stp_q[s_q]) begin
							if (run_vld_q && run_q == s_q) stp_q[s_q] <= 1'b1;
							else act_q[s_q] <= 1'b0;
						end
						OP_REARM: begin
							if (async_q) due_q[s_q] <= now_q;
							if (!keep_q) ival_q[s_q] <= ival_in_q;
							ins_q <= in_tlist;
						end
						OP_WAKE: if (act_q[s_q] && wcnt_q[s_q] != 16'hFFFF)
							wcnt_q[s_q] <= wcnt_q[s_q] + 16'd1;
						OP_READ: begin
							tot_q <= wcnt_q[s_q];
							wcnt_q[s_q] <= '0;
						end
						default: ;
					endcase
				end
				if (op_q == OP_POLL && poll_go) begin
					run_vld_q <= 1'b1; run_q <= poll_slot;
					dv_q <= 1'b1; dt_q <= poll_slot;
				end
				if (op_q == OP_DONE && run_vld_q) begin
					run_vld_q <= 1'b0;
					ins_slot_q <= run_q;
					if (stp_q[run_q] || ival_q[run_q] == '0) begin
						act_q[run_q] <= 1'b0; stp_q[run_q] <= 1'b0;
					end else begin
						due_q[run_q] <= due_q[run_q] + ival_q[run_q];
						ins_q <= 1'b1;
					end
				end
			end
		end
	end

	// result register view
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.dispatch_valid = dv_q;
	assign rsp.dispatched_task = 3'(dt_q);
	assign rsp.wakeup_total = tot_q;
	assign rsp.task_active = ok_q & act_q[s_q];

	logic unused;
	assign unused = ^whead_key;
endmodule

// ----- sv/ttd_checker.sv -----
// Port-level checker for timed_task_dispatcher, bound to the top level.
// Depends on ttd_pkg and the top level's interface ports.
module ttd_checker import ttd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_dispatch_valid,
	input logic [2:0] rsp_dispatched_task,
	input logic [15:0] rsp_wakeup_total
);
	// one request at a time: no request taken while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid)) else $error("request taken during result");
	// a transfer in leads to a result once the remove and insert states have passed
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> ##3 rsp_valid) else $error("result missing");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_dispatched_task)
		&& $stable(rsp_wakeup_total) && $stable(rsp_dispatch_valid)))
		else $error("result changed while stalled");
	// a dispatch never carries a wakeup total
	a_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_dispatch_valid) |-> rsp_wakeup_total == 16'd0)
		else $error("dispatch with total");
endmodule

bind timed_task_dispatcher ttd_checker u_ttd_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_dispatch_valid(rsp.dispatch_valid),
	.rsp_dispatched_task(rsp.dispatched_task),
	.rsp_wakeup_total(rsp.wakeup_total)
);

// ----- tb/sv/scoreboard.sv -----
// Scoreboard for the timed task dispatcher testbench: scheduler state and expected results.
// Depends on ttd_pkg.
package ttd_tb_pkg;
	import ttd_pkg::*;

	typedef struct packed {
		logic        dispatch_valid;
		logic [2:0]  dispatched_task;
		logic [15:0] wakeup_total;
		logic        task_active;
	} sched_result_t;

	class sched_scoreboard;
		logic [TIME_BITS-1:0] due[TASKS];
		logic [TIME_BITS-1:0] ival[TASKS];
		bit                   active[TASKS];
		bit                   stopping[TASKS];
		logic [15:0]          wakes[TASKS];
		int                   time_list[$];
		int                   wake_list[$];
		int                   running;
		sched_result_t        pending[$];
		int                   errors;
		int                   checked;
		int                   dispatches;

		function new();
			for (int i = 0; i < TASKS; i++) begin
				due[i] = '0;
				ival[i] = '0;
				active[i] = 0;
				stopping[i] = 0;
				wakes[i] = '0;
			end
			running = TASKS;
			errors = 0;
			checked = 0;
			dispatches = 0;
		endfunction

		function bit later_or_same(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
			logic [TIME_BITS-1:0] d;
			d = a - b;
			return !d[TIME_BITS-1];
		endfunction

		function void drop(ref int q[$], input int s);
			foreach (q[i]) begin
				if (q[i] == s) begin
					q.delete(i);
					return;
				end
			end
		endfunction

		function bit holds(ref int q[$], input int s);
			foreach (q[i])
				if (q[i] == s)
					return 1;
			return 0;
		endfunction

		// sorted insert; equal due times stay first in, first out
		function void enqueue(int s);
			int pos;
			pos = 0;
			while (pos < time_list.size() && later_or_same(due[s], due[time_list[pos]]))
				pos++;
			time_list.insert(pos, s);
		endfunction

		// note one accepted request and work out its result
		function void note_request(op_t op, logic [2:0] s, logic [TIME_BITS-1:0] now,
			logic [TIME_BITS-1:0] when, logic [TIME_BITS-1:0] iv, bit asy, bit keep);
			sched_result_t r;
			int t;
			r = '0;
			case (op)
				OP_START: begin
					drop(time_list, s);
					drop(wake_list, s);
					due[s] = when;
					ival[s] = iv;
					wakes[s] = '0;
					active[s] = 1;
					stopping[s] = 0;
					enqueue(s);
				end
				OP_STOP: begin
					if (active[s] && !stopping[s]) begin
						if (s == running)
							stopping[s] = 1;
						else begin
							active[s] = 0;
							drop(time_list, s);
							drop(wake_list, s);
						end
					end
				end
				OP_REARM: begin
					if (asy)
						due[s] = now;
					if (!keep)
						ival[s] = iv;
					if (holds(time_list, s)) begin
						drop(time_list, s);
						enqueue(s);
					end
				end
				OP_WAKE: begin
					if (active[s]) begin
						if (wakes[s] == 0 && !holds(wake_list, s))
							wake_list.push_back(s);
						if (wakes[s] != 16'hFFFF)
							wakes[s]++;
					end
				end
				OP_POLL: begin
					if (running == TASKS) begin
						t = TASKS;
						if (wake_list.size() > 0) begin
							t = wake_list.pop_front();
							drop(time_list, t);
						end else if (time_list.size() > 0 &&
							later_or_same(now, due[time_list[0]])) begin
							t = time_list.pop_front();
						end
						if (t < TASKS) begin
							running = t;
							r.dispatch_valid = 1;
							r.dispatched_task = 3'(t);
							dispatches++;
						end
					end
				end
				OP_DONE: begin
					if (running < TASKS) begin
						t = running;
						drop(time_list, t);
						if (stopping[t] || ival[t] == 0) begin
							active[t] = 0;
							stopping[t] = 0;
							drop(wake_list, t);
						end else begin
							due[t] = due[t] + ival[t];
							enqueue(t);
						end
						running = TASKS;
					end
				end
				OP_READ: begin
					r.wakeup_total = wakes[s];
					if (wakes[s] != 0) begin
						wakes[s] = '0;
						drop(wake_list, s);
					end
				end
				default: ;
			endcase
			r.task_active = active[s];
			pending.push_back(r);
		endfunction

		// compare one result with the oldest expectation
		function void check_result(sched_result_t got);
			sched_result_t exp_r;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.dispatch_valid !== exp_r.dispatch_valid)
				report("dispatch_valid", exp_r.dispatch_valid, got.dispatch_valid);
			if (got.dispatched_task !== exp_r.dispatched_task)
				report("dispatched_task", exp_r.dispatched_task, got.dispatched_task);
			if (got.wakeup_total !== exp_r.wakeup_total)
				report("wakeup_total", exp_r.wakeup_total, got.wakeup_total);
			if (got.task_active !== exp_r.task_active)
				report("task_active", exp_r.task_active, got.task_active);
		endfunction

		function void report(string field, logic [15:0] e, logic [15:0] a);
			$display("%0t: %s expected %0h actual %0h", $time, field, e, a);
			errors++;
		endfunction
	endclass
endpackage

// ----- tb/sv/testbench.sv -----
// Testbench top for timed_task_dispatcher: random and directed scheduler requests,
// results checked against the scoreboard. Depends on ttd_pkg, ttd_if, ttd_tb_pkg.
module testbench;
	import ttd_pkg::*;
	import ttd_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   cycles;
	bit   sending;

	ttd_req_if req ();
	ttd_rsp_if rsp ();

	timed_task_dispatcher dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	sched_scoreboard sb;
	logic [TIME_BITS-1:0] clock_now;
	int op_seen[8];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 30)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// result side: random stalls, check each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				sb.check_result({rsp.dispatch_valid, rsp.dispatched_task,
					rsp.wakeup_total, rsp.task_active});
			rsp.ready <= (sending && cycles % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// one request transfer; valid stays high into the next request when there is no gap
	task automatic send(op_t op, int s, logic [TIME_BITS-1:0] now,
		logic [TIME_BITS-1:0] when, logic [TIME_BITS-1:0] iv, int asy, int keep);
		int g;
		g = (cycles % 700 < 150) ? 0 : gap_len();
		if (g > 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1;
		req.op <= op;
		req.task_req <= 3'(s);
		req.now <= now;
		req.when <= when;
		req.interval <= iv;
		req.async_rearm <= 1'(asy);
		req.keep_interval <= 1'(keep);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_request(op, 3'(s), now, when, iv, 1'(asy), 1'(keep));
		op_seen[op]++;
	endtask

	function logic [TIME_BITS-1:0] near_time();
		int p;
		p = $urandom_range(0, 9);
		if (p < 7)
			return clock_now + $urandom_range(0, 60) - 20;
		if (p < 9)
			return clock_now + 32'h8000_0000 + $urandom_range(0, 4) - 2;
		return $urandom();
	endfunction

	function logic [TIME_BITS-1:0] small_interval();
		int p;
		p = $urandom_range(0, 9);
		if (p < 3)
			return 0;
		if (p < 9)
			return $urandom_range(1, 40);
		return $urandom();
	endfunction

	task automatic random_request();
		op_t op;
		int p;
		p = $urandom_range(0, 99);
		// weights favor polls and dones so tasks actually run
		if (p < 15) op = OP_START;
		else if (p < 22) op = OP_STOP;
		else if (p < 32) op = OP_REARM;
		else if (p < 45) op = OP_WAKE;
		else if (p < 70) op = OP_POLL;
		else if (p < 88) op = OP_DONE;
		else if (p < 97) op = OP_READ;
		else op = OP_NOP;
		clock_now = clock_now + $urandom_range(0, 8);
		send(op, $urandom_range(0, 7), ($urandom_range(0, 19) == 0) ? $urandom() : clock_now,
			near_time(), small_interval(), $urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	initial begin
		sb = new();
		cycles = 0;
		sending = 1;
		clock_now = 32'hFFFF_FF00;
		arst_n = 0;
		req.valid = 0;
		req.op = OP_NOP;
		req.task_req = '0;
		req.now = '0;
		req.when = '0;
		req.interval = '0;
		req.async_rearm = 0;
		req.keep_interval = 0;
		rsp.ready = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every op, restart, stops, wrap
		send(OP_POLL, 0, 32'h0, 0, 0, 0, 0);
		send(OP_DONE, 0, 0, 0, 0, 0, 0);
		send(OP_START, 7, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		send(OP_START, 0, 0, 32'hFFFF_FFFF, 5, 0, 0);
		send(OP_START, 3, 0, 32'h0000_0010, 0, 0, 0);
		send(OP_WAKE, 5, 0, 0, 0, 0, 0);
		send(OP_WAKE, 3, 0, 0, 0, 0, 0);
		send(OP_WAKE, 3, 0, 0, 0, 0, 0);
		send(OP_POLL, 0, 32'h0, 0, 0, 0, 0);
		send(OP_POLL, 0, 32'h0, 0, 0, 0, 0);
		send(OP_STOP, 3, 0, 0, 0, 0, 0);
		send(OP_STOP, 3, 0, 0, 0, 0, 0);
		send(OP_START, 3, 0, 32'h20, 7, 0, 0);
		send(OP_DONE, 0, 0, 0, 0, 0, 0);
		send(OP_READ, 3, 0, 0, 0, 0, 0);
		send(OP_REARM, 7, 32'h8000_0000, 0, 32'h1, 1, 0);
		send(OP_REARM, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1, 1);
		send(OP_REARM, 2, 0, 0, 3, 0, 0);
		send(OP_POLL, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
		send(OP_STOP, 1, 0, 0, 0, 0, 0);
		send(OP_STOP, 7, 0, 0, 0, 0, 0);
		send(OP_DONE, 0, 0, 0, 0, 0, 0);
		send(OP_READ, 6, 0, 0, 0, 0, 0);
		send(OP_NOP, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);

		// random traffic
		repeat (1300) random_request();

		// far-future start, then read its cleared count
		send(OP_START, 2, 0, clock_now + 32'h4000_0000, 0, 0, 0);
		send(OP_READ, 2, 0, 0, 0, 0, 0);
		req.valid <= 0;

		// drain
		sending = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d results; %0d dispatches; op counts %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
			sb.checked, sb.dispatches, op_seen[0], op_seen[1], op_seen[2], op_seen[3],
			op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
		$display("Covered restarts, stops, rearms, wakeup reads and wrap-around due times");
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
sv/ttd_pkg.sv
sv/ttd_if.sv
sv/ttd_cell.sv
sv/ttd_chain.sv
sv/timed_task_dispatcher.sv
sv/ttd_checker.sv
tb/sv/scoreboard.sv
tb/sv/testbench.sv
